/* sv/pidc_pkg.sv */
// Shared types and constants for the clamped PID controller.
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int OUT_MAX        = 100;
  localparam int DRIVE_W        = 7;
  localparam int GAIN_W         = 16;
  localparam int MAXERR_W       = 16;
  localparam int MSE_W          = 31;
  localparam int SUM_W          = 32;
  localparam int ERR_W          = DATA_WIDTH + 1;
  localparam int P_W            = GAIN_W + ERR_W;
  localparam int I_W            = GAIN_W + SUM_W;
  localparam int D_W            = GAIN_W + ERR_W;
  localparam int ACC_W          = I_W + 2;
  localparam int APB_DW         = 32;
  localparam int ADDR_W         = 5;
  localparam int IDX_W          = 3;

  localparam logic [IDX_W-1:0] REG_KP        = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI        = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD        = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ERROR = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_SUM   = 3'd4;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_TOP,
    SAT_BOTTOM
  } sat_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [MAXERR_W-1:0]      max_error;
    logic [MSE_W-1:0]         max_sum_error;
  } cfg_t;

endpackage
`default_nettype wire

/* sv/pidc_regs.sv */
// APB configuration registers of the PID controller.
`timescale 1ns / 1ps
`default_nettype none
module pidc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pidc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pidc_pkg::APB_DW-1:0]  pwdata,
  output logic      [pidc_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output pidc_pkg::cfg_t                    cfg
);
  import pidc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp            <= '0;
      cfg.ki            <= '0;
      cfg.kd            <= '0;
      cfg.max_error     <= '1;
      cfg.max_sum_error <= '1;
    end else if (wr) begin
      case (idx)
        REG_KP:        cfg.kp            <= pwdata[GAIN_W-1:0];
        REG_KI:        cfg.ki            <= pwdata[GAIN_W-1:0];
        REG_KD:        cfg.kd            <= pwdata[GAIN_W-1:0];
        REG_MAX_ERROR: cfg.max_error     <= pwdata[MAXERR_W-1:0];
        REG_MAX_SUM:   cfg.max_sum_error <= pwdata[MSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:        prdata = APB_DW'(unsigned'(cfg.kp));
      REG_KI:        prdata = APB_DW'(unsigned'(cfg.ki));
      REG_KD:        prdata = APB_DW'(unsigned'(cfg.kd));
      REG_MAX_ERROR: prdata = APB_DW'(cfg.max_error);
      REG_MAX_SUM:   prdata = APB_DW'(cfg.max_sum_error);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/pid_controller_clamped.sv */
// A step beat passes through stage 1, stage 2 and stage 3 to become a drive beat; a clear beat gives no drive beat.
// Throughput: one beat per cycle; the pipeline stalls as a whole while a drive beat waits.
// Stage 1 updates the error sum and previous measurement, stage 2 forms the three
// gain products, stage 3 sums, truncates and clamps into the output register.
// Reset (rst, synchronous): pipeline empty, error sum and previous measurement zero,
// gains zero, both limits all ones.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_clamped (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 opcode,
  input  wire logic signed [pidc_pkg::DATA_WIDTH-1:0] setpoint,
  input  wire logic signed [pidc_pkg::DATA_WIDTH-1:0] measurement,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [pidc_pkg::DRIVE_W-1:0]  drive,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic        [pidc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic        [pidc_pkg::APB_DW-1:0]   pwdata,
  output logic             [pidc_pkg::APB_DW-1:0]   prdata,
  output logic                                      pready
);
  import pidc_pkg::*;

  cfg_t cfg;

  pidc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic en;
  logic accept;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // controller state
  logic signed [SUM_W-1:0]      error_sum;
  logic signed [DATA_WIDTH-1:0] previous_measurement;

  // stage 1: error, integrator, limits
  logic signed [ERR_W-1:0]   err_c;
  logic signed [ERR_W:0]     err_x;
  logic signed [ERR_W:0]     max_err_s;
  logic signed [SUM_W:0]     t_c;
  logic signed [SUM_W:0]     mse_s;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [ERR_W-1:0]   dmeas_c;
  sat_t                      psel_c;
  sat_t                      isat_c;

  assign err_c     = ERR_W'(setpoint) - ERR_W'(measurement);
  assign err_x     = (ERR_W+1)'(err_c);
  assign max_err_s = signed'((ERR_W+1)'(cfg.max_error));
  assign t_c       = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err_c);
  assign mse_s     = signed'((SUM_W+1)'(cfg.max_sum_error));
  assign dmeas_c   = ERR_W'(previous_measurement) - ERR_W'(measurement);

  always_comb begin
    if (err_x > max_err_s) begin
      psel_c = SAT_TOP;
    end else if (err_x < -max_err_s) begin
      psel_c = SAT_BOTTOM;
    end else begin
      psel_c = SAT_NONE;
    end
    if (t_c > mse_s) begin
      isat_c   = SAT_TOP;
      sum_next = SUM_W'(mse_s);
    end else if (t_c < -mse_s) begin
      isat_c   = SAT_BOTTOM;
      sum_next = SUM_W'(-mse_s);
    end else begin
      isat_c   = SAT_NONE;
      sum_next = t_c[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum            <= '0;
      previous_measurement <= '0;
    end else if (accept) begin
      if (opcode == OP_CLEAR) begin
        error_sum <= '0;
      end else begin
        error_sum            <= sum_next;
        previous_measurement <= measurement;
      end
    end
  end

  logic                    s1_valid;
  logic signed [ERR_W-1:0] s1_err;
  logic signed [SUM_W-1:0] s1_sum;
  logic signed [ERR_W-1:0] s1_dmeas;
  sat_t                    s1_psel;
  sat_t                    s1_isat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && (opcode == OP_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err   <= err_c;
      s1_sum   <= sum_next;
      s1_dmeas <= dmeas_c;
      s1_psel  <= psel_c;
      s1_isat  <= isat_c;
    end
  end

  // stage 2: gain products
  logic signed [P_W-1:0] p_mul;
  logic signed [P_W-1:0] p_max;
  logic signed [P_W-1:0] p_c;
  logic signed [I_W-1:0] i_mul;
  logic signed [I_W-1:0] i_c;
  logic signed [D_W-1:0] d_mul;

  assign p_mul = cfg.kp * s1_err;
  assign p_max = signed'(P_W'({cfg.max_error, {GAIN_FRAC_BITS{1'b0}}}));
  assign i_mul = cfg.ki * s1_sum;
  assign d_mul = cfg.kd * s1_dmeas;

  always_comb begin
    case (s1_psel)
      SAT_TOP:    p_c = p_max;
      SAT_BOTTOM: p_c = -p_max;
      default:    p_c = p_mul;
    endcase
    i_c = (s1_isat == SAT_NONE) ? i_mul : '0;
  end

  logic                  s2_valid;
  logic signed [P_W-1:0] s2_p;
  logic signed [I_W-1:0] s2_i;
  logic signed [D_W-1:0] s2_d;
  sat_t                  s2_isat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p    <= p_c;
      s2_i    <= i_c;
      s2_d    <= d_mul;
      s2_isat <= s1_isat;
    end
  end

  // stage 3: sum, truncate, clamp
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;
  logic [DRIVE_W-1:0]      drive_next;

  assign acc = ACC_W'(s2_p) + ACC_W'(s2_i) + ACC_W'(s2_d);
  assign q   = acc >>> GAIN_FRAC_BITS;

  always_comb begin
    case (s2_isat)
      SAT_TOP:    drive_next = DRIVE_W'(OUT_MAX);
      SAT_BOTTOM: drive_next = '0;
      default: begin
        if (acc[ACC_W-1] || acc == '0) begin
          drive_next = '0;
        end else if ((|q[ACC_W-1:DRIVE_W]) || (q[DRIVE_W-1:0] > DRIVE_W'(OUT_MAX))) begin
          drive_next = DRIVE_W'(OUT_MAX);
        end else begin
          drive_next = q[DRIVE_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drive <= drive_next;
    end
  end

endmodule
`default_nettype wire

/* sv/pidc_checker.sv */
// Port-level checks for the PID controller and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pidc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [pidc_pkg::DRIVE_W-1:0]  drive
);
  import pidc_pkg::*;

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= DRIVE_W'(OUT_MAX)))
    else $error("drive beat above full scale");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("drive beat right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output can advance");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive)))
    else $error("stalled drive beat dropped or changed");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the clamped PID controller: stream beats, APB setup, drive scoreboard.
module testbench;
  import pidc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 125;

  typedef struct packed {
    logic                           op;
    logic signed [DATA_WIDTH-1:0]   sp;
    logic signed [DATA_WIDTH-1:0]   meas;
  } sample_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  wire                            in_ready;
  logic                           opcode = OP_STEP;
  logic signed [DATA_WIDTH-1:0]   setpoint = '0;
  logic signed [DATA_WIDTH-1:0]   measurement = '0;
  wire                            out_valid;
  logic                           out_ready = 1'b0;
  wire         [DRIVE_W-1:0]      drive;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic        [ADDR_W-1:0]       paddr = '0;
  logic        [APB_DW-1:0]       pwdata = '0;
  wire         [APB_DW-1:0]       prdata;
  wire                            pready;

  cfg_t                           cfg_shadow;
  logic signed [SUM_W-1:0]        err_sum;
  logic signed [DATA_WIDTH-1:0]   last_meas;
  sample_t                        pending_samples[$];
  logic        [DRIVE_W-1:0]      expected_drive[$];
  sample_t                        held;
  logic        [DRIVE_W-1:0]      want;
  int                             errors = 0;
  int                             tx_gap = 0;
  int                             rx_stall = 0;
  int                             idle_cycles = 0;
  bit                             steady = 1'b0;

  pid_controller_clamped u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .setpoint(setpoint),
    .measurement(measurement),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive(drive),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void predict_step(sample_t s);
    longint err, p_term, i_term, d_term, total, lim_e, lim_s, acc;
    sat_t sat;
    logic [DRIVE_W-1:0] q;
    if (s.op == OP_CLEAR) begin
      err_sum = '0;
      return;
    end
    err = longint'($signed(s.sp)) - longint'($signed(s.meas));
    lim_e = longint'(cfg_shadow.max_error);
    lim_s = longint'(cfg_shadow.max_sum_error);
    if (err > lim_e) p_term = lim_e <<< GAIN_FRAC_BITS;
    else if (err < -lim_e) p_term = -(lim_e <<< GAIN_FRAC_BITS);
    else p_term = longint'($signed(cfg_shadow.kp)) * err;
    acc = longint'(err_sum) + err;
    i_term = 0;
    if (acc > lim_s) begin
      sat = SAT_TOP;
      err_sum = SUM_W'(lim_s);
    end else if (acc < -lim_s) begin
      sat = SAT_BOTTOM;
      err_sum = SUM_W'(-lim_s);
    end else begin
      sat = SAT_NONE;
      err_sum = SUM_W'(acc);
      i_term = longint'($signed(cfg_shadow.ki)) * acc;
    end
    d_term = longint'($signed(cfg_shadow.kd)) * (longint'(last_meas) - longint'($signed(s.meas)));
    last_meas = s.meas;
    case (sat)
      SAT_TOP: q = DRIVE_W'(OUT_MAX);
      SAT_BOTTOM: q = '0;
      default: begin
        total = p_term + i_term + d_term;
        if (total <= 0) q = '0;
        else if ((total >>> GAIN_FRAC_BITS) > OUT_MAX) q = DRIVE_W'(OUT_MAX);
        else q = DRIVE_W'(total >>> GAIN_FRAC_BITS);
      end
    endcase
    expected_drive.push_back(q);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int r;
    r = $urandom_range(0, 99);
    s.op = (r < 8) ? OP_CLEAR : OP_STEP;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      s.sp = DATA_WIDTH'(int'($urandom_range(0, 400)) - 200);
      s.meas = DATA_WIDTH'(int'($urandom_range(0, 400)) - 200);
    end else if (r < 80) begin
      s.meas = DATA_WIDTH'($urandom);
      s.sp = s.meas + DATA_WIDTH'(int'($urandom_range(0, 64)) - 32);
    end else begin
      s.sp = DATA_WIDTH'($urandom);
      s.meas = DATA_WIDTH'($urandom);
    end
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    if ($urandom_range(0, 6) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
  endfunction

  function automatic logic [MAXERR_W-1:0] pick_err_limit();
    if ($urandom_range(0, 9) < 3) return MAXERR_W'($urandom);
    return MAXERR_W'($urandom_range(0, 400));
  endfunction

  function automatic logic [MSE_W-1:0] pick_sum_limit();
    if ($urandom_range(0, 4) == 0) return MSE_W'($urandom);
    return MSE_W'($urandom_range(0, 20000));
  endfunction

  task automatic queue_sample(input logic op, input int sp, input int meas);
    sample_t s;
    s.op = op;
    s.sp = DATA_WIDTH'(sp);
    s.meas = DATA_WIDTH'(meas);
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KP: cfg_shadow.kp = value[GAIN_W-1:0];
      REG_KI: cfg_shadow.ki = value[GAIN_W-1:0];
      REG_KD: cfg_shadow.kd = value[GAIN_W-1:0];
      REG_MAX_ERROR: cfg_shadow.max_error = value[MAXERR_W-1:0];
      REG_MAX_SUM: cfg_shadow.max_sum_error = value[MSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [GAIN_W-1:0] g_p, input logic [GAIN_W-1:0] g_i,
                           input logic [GAIN_W-1:0] g_d, input logic [MAXERR_W-1:0] lim_e,
                           input logic [MSE_W-1:0] lim_s);
    write_reg(REG_KP, {16'($urandom), g_p});
    write_reg(REG_KI, {16'($urandom), g_i});
    write_reg(REG_KD, {16'($urandom), g_d});
    write_reg(REG_MAX_ERROR, {16'($urandom), lim_e});
    write_reg(REG_MAX_SUM, {1'($urandom), lim_s});
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_drive.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_shadow.kp = '0;
    cfg_shadow.ki = '0;
    cfg_shadow.kd = '0;
    cfg_shadow.max_error = '1;
    cfg_shadow.max_sum_error = '1;
    err_sum = '0;
    last_meas = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    repeat (4) pending_samples.push_back(rand_sample());
    drain();

    write_reg(REG_UNUSED, $urandom);
    configure(16'h0100, 16'h0010, 16'h0080, 16'd200, 31'd5000);
    queue_sample(OP_STEP, 0, 0);
    queue_sample(OP_STEP, 100, 50);
    queue_sample(OP_STEP, -100, 0);
    queue_sample(OP_STEP, 300, 0);
    queue_sample(OP_STEP, -300, 0);
    queue_sample(OP_CLEAR, 32767, -32768);
    queue_sample(OP_STEP, 32767, -32768);
    queue_sample(OP_STEP, 32767, -32768);
    queue_sample(OP_CLEAR, -32768, 32767);
    queue_sample(OP_STEP, -32768, 32767);
    queue_sample(OP_CLEAR, 0, 0);
    queue_sample(OP_STEP, 32767, 32767);
    queue_sample(OP_STEP, -32768, -32768);
    queue_sample(OP_STEP, 0, -32768);
    queue_sample(OP_STEP, 0, 32767);
    queue_sample(OP_STEP, 150, 100);
    queue_sample(OP_STEP, 200, 0);
    queue_sample(OP_STEP, -200, 0);
    queue_sample(OP_CLEAR, 0, 0);
    queue_sample(OP_STEP, 5, 5);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(16'h7fff, 16'h7fff, 16'h7fff, '1, '1);
        1: configure(16'h8000, 16'h8000, 16'h8000, '0, '0);
        2: configure(16'h8000, 16'h7fff, 16'h0000, '1, '0);
        default: configure(pick_gain(), pick_gain(), pick_gain(), pick_err_limit(),
                           pick_sum_limit());
      endcase
      steady = (ph % 4 == 3);
      repeat (PHASE_ITEMS) pending_samples.push_back(rand_sample());
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_step(held);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          held = pending_samples.pop_front();
          opcode <= held.op;
          setpoint <= held.sp;
          measurement <= held.meas;
          in_valid <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $error("drive beat with no step pending: actual %0d", drive);
          errors++;
        end else begin
          want = expected_drive.pop_front();
          if (drive !== want) begin
            $error("drive mismatch: expected %0d actual %0d", want, drive);
            errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
sv/pidc_pkg.sv
sv/pidc_regs.sv
sv/pid_controller_clamped.sv
sv/pidc_checker.sv
dv/testbench.sv
